// File: sv/ring_queue_bulk_pop_top_assert.svh
// Assertion macros for the ring queue with bulk pop.
// Used by the port checker; needs clk_i and rst_ni in the scope of each use.
`ifndef RING_QUEUE_BULK_POP_TOP_ASSERT_SVH
`define RING_QUEUE_BULK_POP_TOP_ASSERT_SVH

// Checks a property on every rising clock edge while reset is released.
`define RQBP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

// Checks that a condition holds whenever the output channel presents an item.
`define RQBP_ASSERT_OUT(lbl, cond, msg) \
  `RQBP_ASSERT(lbl, m_axis_tvalid |-> (cond), msg)

`endif

// File: sv/rqbp_pkg.sv
// Shared types, constants and index arithmetic for the ring queue with bulk pop.
// No dependencies; every module file of the block imports this package.
`timescale 1ns / 1ps

package rqbp_pkg;

  // Queue geometry.
  localparam int unsigned QueueDepth = 1024;
  localparam int unsigned IdxW       = $clog2(QueueDepth);
  localparam int unsigned DataW      = 64;
  localparam int unsigned CntW       = 10;
  localparam int unsigned OccW       = 10;
  localparam int unsigned CmpW       = (IdxW > CntW) ? IdxW : CntW;

  // Packed bus widths, rounded up to whole bytes.
  localparam int unsigned InBitsW  = 2 + DataW + CntW;
  localparam int unsigned OutBitsW = 1 + DataW + OccW + 2;
  localparam int unsigned InTdataW  = ((InBitsW + 7) / 8) * 8;
  localparam int unsigned OutTdataW = ((OutBitsW + 7) / 8) * 8;

  typedef logic [IdxW-1:0]  idx_t;
  typedef logic [DataW-1:0] data_t;

  // Request kinds.
  typedef enum logic [1:0] {
    OP_PUSH = 2'd0,
    OP_POP  = 2'd1,
    OP_READ = 2'd2
  } op_e;

  // Access issued to the slot memory.
  typedef struct packed {
    logic  we;
    logic  re;
    idx_t  addr;
    data_t wdata;
  } mem_req_t;

  // Result of one request, except for the read word.
  typedef struct packed {
    logic            ok;
    logic            rd;
    logic [OccW-1:0] occupancy;
    logic            is_empty;
    logic            is_full;
  } result_t;

  // Adds two indices modulo the depth; both operands are below the depth.
  function automatic idx_t wrap_add(idx_t a, idx_t b);
    logic [IdxW:0] sum;
    sum = {1'b0, a} + {1'b0, b};
    if (sum >= (IdxW+1)'(QueueDepth)) begin
      sum = sum - (IdxW+1)'(QueueDepth);
    end
    return sum[IdxW-1:0];
  endfunction

  // Number of entries held between head and tail.
  function automatic idx_t held_of(idx_t head, idx_t tail);
    logic [IdxW:0] span;
    span = {1'b0, tail} + (IdxW+1)'(QueueDepth - 1) - {1'b0, head};
    if (span >= (IdxW+1)'(QueueDepth)) begin
      span = span - (IdxW+1)'(QueueDepth);
    end
    return span[IdxW-1:0];
  endfunction

endpackage

// File: sv/rqbp_ram.sv
// Slot memory of the ring queue: one port, registered read.
// Depends on rqbp_pkg for the geometry and the request struct.
`timescale 1ns / 1ps

module rqbp_ram (
  input  logic             clk_i,
  input  rqbp_pkg::mem_req_t req_i,
  output rqbp_pkg::data_t  rdata_o
);
  import rqbp_pkg::*;

  data_t mem [QueueDepth];
  data_t rdata_q;

  // Write on a push; read data is captured only when a read is issued.
  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem[req_i.addr] <= req_i.wdata;
    end
    if (req_i.re) begin
      rdata_q <= mem[req_i.addr];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: sv/rqbp_ctrl.sv
// Head and tail bookkeeping of the ring queue; decides each request and
// drives the slot memory. Depends on rqbp_pkg.
`timescale 1ns / 1ps

module rqbp_ctrl (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       accept_i,
  input  logic [1:0]                 op_i,
  input  rqbp_pkg::data_t            value_i,
  input  logic [rqbp_pkg::CntW-1:0]  count_i,
  output rqbp_pkg::mem_req_t         mem_req_o,
  output rqbp_pkg::result_t          result_o
);
  import rqbp_pkg::*;

  idx_t head_q, head_d;
  idx_t tail_q, tail_d;
  idx_t held, held_next;
  idx_t cnt_idx;
  logic [CmpW-1:0] cnt_cmp, held_cmp;
  logic ok, rd;

  assign held     = held_of(head_q, tail_q);
  assign cnt_idx  = IdxW'(count_i);
  assign cnt_cmp  = CmpW'(count_i);
  assign held_cmp = CmpW'(held);

  // Decide the request and compute the new indices and occupancy.
  always_comb begin
    head_d    = head_q;
    tail_d    = tail_q;
    held_next = held;
    ok        = 1'b0;
    rd        = 1'b0;
    mem_req_o = '0;
    mem_req_o.wdata = value_i;
    unique case (op_i)
      OP_PUSH: begin
        if (head_q != tail_q) begin
          ok             = 1'b1;
          mem_req_o.we   = accept_i;
          mem_req_o.addr = tail_q;
          tail_d         = wrap_add(tail_q, idx_t'(1));
          held_next      = held + idx_t'(1);
        end
      end
      OP_POP: begin
        if (cnt_cmp <= held_cmp) begin
          ok        = 1'b1;
          head_d    = wrap_add(head_q, cnt_idx);
          held_next = held - cnt_idx;
        end
      end
      OP_READ: begin
        if (cnt_cmp < held_cmp) begin
          ok             = 1'b1;
          rd             = 1'b1;
          mem_req_o.re   = accept_i;
          mem_req_o.addr = wrap_add(wrap_add(head_q, idx_t'(1)), cnt_idx);
        end
      end
      default: begin
        ok = 1'b0;
      end
    endcase
  end

  // Result fields for the output stage.
  always_comb begin
    result_o.ok        = ok;
    result_o.rd        = rd;
    result_o.occupancy = OccW'(held_next);
    result_o.is_empty  = (held_next == '0);
    result_o.is_full   = (held_next == idx_t'(QueueDepth - 1));
  end

  // Indices move only when an item is accepted.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q <= '0;
      tail_q <= idx_t'(1);
    end else if (accept_i) begin
      head_q <= head_d;
      tail_q <= tail_d;
    end
  end

endmodule

// File: sv/ring_queue_bulk_pop_top.sv
// Ring queue of 64-bit words with push, bulk pop and read at an offset.
// A request accepted at one edge has its result on the output from the next
// cycle on. A new request is taken every cycle as long as no result is held
// or the held result is taken at the same time; the output handshake sets the
// pace. The registered read word of the single-port slot memory lands with the
// result register. One slot is kept free, so the queue holds at most depth
// minus one entries. Depends on rqbp_pkg, rqbp_ctrl and rqbp_ram.
`timescale 1ns / 1ps

module ring_queue_bulk_pop_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // operation [1:0], item_value [65:2], count [75:66], zero [79:76]
  input  logic [rqbp_pkg::InTdataW-1:0]  s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // ok [0], read_value [64:1], occupancy [74:65], is_empty [75], is_full [76],
  // zero [79:77]
  output logic [rqbp_pkg::OutTdataW-1:0] m_axis_tdata
);
  import rqbp_pkg::*;

  logic      accept;
  mem_req_t  mem_req;
  result_t   result, res_q;
  data_t     rdata, read_value;
  logic      valid_q;

  assign s_axis_tready = !valid_q || m_axis_tready;
  assign accept        = s_axis_tvalid && s_axis_tready;

  rqbp_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .accept_i  (accept),
    .op_i      (s_axis_tdata[1:0]),
    .value_i   (s_axis_tdata[DataW+1:2]),
    .count_i   (s_axis_tdata[DataW+CntW+1:DataW+2]),
    .mem_req_o (mem_req),
    .result_o  (result)
  );

  rqbp_ram u_ram (
    .clk_i   (clk_i),
    .req_i   (mem_req),
    .rdata_o (rdata)
  );

  // Output stage: valid flag with reset, result payload without.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      res_q <= result;
    end
  end

  // The read word is shown only for a successful read.
  assign read_value    = res_q.rd ? rdata : '0;
  assign m_axis_tvalid = valid_q;
  assign m_axis_tdata  = OutTdataW'({res_q.is_full, res_q.is_empty, res_q.occupancy,
                                     read_value, res_q.ok});

endmodule

// File: sv/rqbp_checker.sv
// Port-level checker for the ring queue with bulk pop, bound to the top level.
// Depends on rqbp_pkg and the assertion macros header.
`timescale 1ns / 1ps
`include "ring_queue_bulk_pop_top_assert.svh"

module rqbp_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic [rqbp_pkg::InTdataW-1:0]  s_axis_tdata,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [rqbp_pkg::OutTdataW-1:0] m_axis_tdata
);
  import rqbp_pkg::*;

  logic [InTdataW-1:0] in_unused;
  logic                ok, is_empty, is_full;
  logic [OccW-1:0]     occupancy;
  data_t               read_value;

  assign in_unused  = s_axis_tdata;
  assign ok         = m_axis_tdata[0];
  assign read_value = m_axis_tdata[DataW:1];
  assign occupancy  = m_axis_tdata[DataW+OccW:DataW+1];
  assign is_empty   = m_axis_tdata[DataW+OccW+1];
  assign is_full    = m_axis_tdata[DataW+OccW+2];

  // A refused request never carries a read word.
  `RQBP_ASSERT_OUT(a_refused_no_data, ok || (read_value == '0), "refused item has data")
  // Empty implies a zero count, and empty and full exclude each other.
  `RQBP_ASSERT_OUT(a_empty_count, !is_empty || (occupancy == '0), "empty with count")
  `RQBP_ASSERT_OUT(a_empty_full, !(is_empty && is_full), "empty and full at once")
  // Every accepted item shows up on the output in the next cycle.
  `RQBP_ASSERT(a_latency, (s_axis_tvalid && s_axis_tready && (in_unused == in_unused)) |=> m_axis_tvalid, "result missing")
  // A stalled result holds its value.
  `RQBP_ASSERT(a_stall_hold, (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)), "stalled result changed")

endmodule

bind ring_queue_bulk_pop_top rqbp_checker u_rqbp_checker (.*);
